/* design/av1sh_pkg.sv */
// Package for the AV1 sequence header parser.
// Holds the parse phase and control state enumerations, the code constants and the field structs; no dependencies.
package av1sh_pkg;

    typedef enum logic [5:0] {
        PH_PROFILE, PH_STILL, PH_REDUCED, PH_RLEVEL, PH_TIMING, PH_UNITS, PH_SCALE,
        PH_EQUAL, PH_UVLC_PRE, PH_UVLC_VAL, PH_DMI, PH_BDL, PH_DMI_REST, PH_IDD,
        PH_OPCNT, PH_IDC, PH_SLEVEL, PH_STIER, PH_DMPRES, PH_DECDLY, PH_ENCDLY,
        PH_LOWDLY, PH_IDDPRES, PH_IDDVAL, PH_FWB, PH_FHB, PH_MFW, PH_MFH,
        PH_FRAMEID, PH_FRAMEID_LEN, PH_SB3, PH_TOOLS4, PH_ORDERHINT, PH_JNT,
        PH_CHOOSE_SCT, PH_FORCE_SCT, PH_CHOOSE_IMV, PH_FORCE_IMV, PH_OHBITS,
        PH_TAIL3, PH_HBD, PH_TWELVE, PH_MONO, PH_CDP, PH_CP, PH_TC, PH_MC,
        PH_RANGE, PH_SUBX, PH_SUBY, PH_CSP, PH_SEPUV, PH_GRAIN
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_OUT
    } ctrl_t;

    localparam logic [5:0] UVLC_MAX = 6'd32;
    localparam logic [7:0] CODE_UNSPEC = 8'd2;
    localparam logic [7:0] CP_BT709 = 8'd1;
    localparam logic [7:0] TC_SRGB = 8'd13;
    localparam logic [7:0] MC_IDENTITY = 8'd0;

    typedef struct packed {
        logic [2:0] profile;
        logic [4:0] level;
        logic       tier;
        logic [3:0] bit_depth;
        logic       monochrome;
        logic [3:0] chroma_format;
        logic       cdp;
        logic [7:0] cp;
        logic [7:0] tc;
        logic [7:0] mc;
        logic       color_range;
    } fields_t;

    typedef struct packed {
        logic       bit_valid;
        logic       bit_value;
        logic       restart;
    } bit_ctrl_t;

    typedef struct packed {
        logic       done;
        logic       grain;
    } bit_stat_t;

endpackage

/* design/av1sh_bit_parser.sv */
// Bit-serial field walker of the AV1 sequence header parser.
// Takes one header bit per valid cycle until done, keeps decoded fields; uses av1sh_pkg
module av1sh_bit_parser
    import av1sh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  bit_ctrl_t ctrl,
    output bit_stat_t stat,
    output fields_t   fields
);

    phase_t     phase_reg, phase_next;
    logic [5:0] count_reg, count_next;
    logic [7:0] value_reg, value_next;
    logic [4:0] op_idx_reg, op_idx_next;
    logic [4:0] op_tot_reg, op_tot_next;
    logic [4:0] dly_reg, dly_next;
    logic [3:0] sbw_reg, sbw_next;
    logic [3:0] sbh_reg, sbh_next;
    logic [5:0] uvlc_reg, uvlc_next;
    logic       fl_red_reg, fl_red_next;
    logic       fl_dmi_reg, fl_dmi_next;
    logic       fl_idd_reg, fl_idd_next;
    logic       fl_oh_reg, fl_oh_next;
    logic       done_reg, done_next;
    fields_t    f_reg, f_next;

    logic [5:0] flen;
    logic [5:0] cnt_inc;
    logic [7:0] v;

    // The film grain field is one bit long, so the next bit always completes the header.
    assign stat.done  = done_reg;
    assign stat.grain = (phase_reg == PH_GRAIN) && !done_reg;
    assign fields     = f_reg;

    always_comb
    begin
        case (phase_reg)
            PH_PROFILE, PH_TAIL3, PH_SB3, PH_OHBITS: flen = 6'd3;
            PH_RLEVEL, PH_BDL, PH_OPCNT, PH_SLEVEL: flen = 6'd5;
            PH_UNITS, PH_SCALE: flen = 6'd32;
            PH_UVLC_VAL: flen = uvlc_reg;
            PH_DMI_REST: flen = 6'd42;
            PH_IDC: flen = 6'd12;
            PH_DECDLY, PH_ENCDLY: flen = {1'b0, dly_reg} + 6'd1;
            PH_IDDVAL, PH_FWB, PH_FHB, PH_TOOLS4: flen = 6'd4;
            PH_MFW: flen = {2'b00, sbw_reg} + 6'd1;
            PH_MFH: flen = {2'b00, sbh_reg} + 6'd1;
            PH_FRAMEID_LEN: flen = 6'd7;
            PH_JNT, PH_CSP: flen = 6'd2;
            PH_CP, PH_TC, PH_MC: flen = 6'd8;
            default: flen = 6'd1;
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        value_next  = value_reg;
        op_idx_next = op_idx_reg;
        op_tot_next = op_tot_reg;
        dly_next    = dly_reg;
        sbw_next    = sbw_reg;
        sbh_next    = sbh_reg;
        uvlc_next   = uvlc_reg;
        fl_red_next = fl_red_reg;
        fl_dmi_next = fl_dmi_reg;
        fl_idd_next = fl_idd_reg;
        fl_oh_next  = fl_oh_reg;
        done_next   = done_reg;
        f_next      = f_reg;
        v           = {value_reg[6:0], ctrl.bit_value};
        cnt_inc     = count_reg + 6'd1;

        if (ctrl.bit_valid && !done_reg)
        begin
            value_next = v;
            count_next = cnt_inc;
            if (cnt_inc >= flen)
            begin
                count_next = '0;
                value_next = '0;
                case (phase_reg)
                    PH_PROFILE:
                    begin
                        f_next.profile = v[2:0];
                        phase_next = PH_STILL;
                    end
                    PH_STILL: phase_next = PH_REDUCED;
                    PH_REDUCED:
                    begin
                        if (v[0])
                        begin
                            fl_red_next = 1'b1;
                            phase_next = PH_RLEVEL;
                        end
                        else
                        begin
                            phase_next = PH_TIMING;
                        end
                    end
                    PH_RLEVEL:
                    begin
                        f_next.level = v[4:0];
                        f_next.tier = 1'b0;
                        phase_next = PH_FWB;
                    end
                    PH_TIMING: phase_next = v[0] ? PH_UNITS : PH_IDD;
                    PH_UNITS: phase_next = PH_SCALE;
                    PH_SCALE: phase_next = PH_EQUAL;
                    PH_EQUAL:
                    begin
                        uvlc_next = '0;
                        phase_next = v[0] ? PH_UVLC_PRE : PH_DMI;
                    end
                    PH_UVLC_PRE:
                    begin
                        if (!v[0])
                        begin
                            if (uvlc_reg < UVLC_MAX)
                            begin
                                uvlc_next = uvlc_reg + 6'd1;
                            end
                        end
                        else
                        begin
                            phase_next = (uvlc_reg == 6'd0 || uvlc_reg >= UVLC_MAX)
                                         ? PH_DMI : PH_UVLC_VAL;
                        end
                    end
                    PH_UVLC_VAL: phase_next = PH_DMI;
                    PH_DMI:
                    begin
                        if (v[0])
                        begin
                            fl_dmi_next = 1'b1;
                            phase_next = PH_BDL;
                        end
                        else
                        begin
                            phase_next = PH_IDD;
                        end
                    end
                    PH_BDL:
                    begin
                        dly_next = v[4:0];
                        phase_next = PH_DMI_REST;
                    end
                    PH_DMI_REST: phase_next = PH_IDD;
                    PH_IDD:
                    begin
                        if (v[0])
                        begin
                            fl_idd_next = 1'b1;
                        end
                        phase_next = PH_OPCNT;
                    end
                    PH_OPCNT:
                    begin
                        op_tot_next = v[4:0];
                        op_idx_next = '0;
                        phase_next = PH_IDC;
                    end
                    PH_IDC: phase_next = PH_SLEVEL;
                    PH_SLEVEL:
                    begin
                        if (op_idx_reg == 5'd0)
                        begin
                            f_next.level = v[4:0];
                            f_next.tier = 1'b0;
                        end
                        if (v > 8'd7)
                        begin
                            phase_next = PH_STIER;
                        end
                        else
                        begin
                            phase_next = PH_DMPRES;
                        end
                    end
                    PH_STIER:
                    begin
                        if (op_idx_reg == 5'd0)
                        begin
                            f_next.tier = v[0];
                        end
                        phase_next = PH_DMPRES;
                    end
                    PH_DMPRES: phase_next = v[0] ? PH_DECDLY : PH_IDDPRES;
                    PH_DECDLY: phase_next = PH_ENCDLY;
                    PH_ENCDLY: phase_next = PH_LOWDLY;
                    PH_LOWDLY: phase_next = PH_IDDPRES;
                    PH_IDDPRES: phase_next = v[0] ? PH_IDDVAL : PH_FWB;
                    PH_IDDVAL: phase_next = PH_FWB;
                    PH_FWB:
                    begin
                        sbw_next = v[3:0];
                        phase_next = PH_FHB;
                    end
                    PH_FHB:
                    begin
                        sbh_next = v[3:0];
                        phase_next = PH_MFW;
                    end
                    PH_MFW: phase_next = PH_MFH;
                    PH_MFH: phase_next = fl_red_reg ? PH_SB3 : PH_FRAMEID;
                    PH_FRAMEID: phase_next = v[0] ? PH_FRAMEID_LEN : PH_SB3;
                    PH_FRAMEID_LEN: phase_next = PH_SB3;
                    PH_SB3: phase_next = fl_red_reg ? PH_TAIL3 : PH_TOOLS4;
                    PH_TOOLS4: phase_next = PH_ORDERHINT;
                    PH_ORDERHINT:
                    begin
                        if (v[0])
                        begin
                            fl_oh_next = 1'b1;
                            phase_next = PH_JNT;
                        end
                        else
                        begin
                            phase_next = PH_CHOOSE_SCT;
                        end
                    end
                    PH_JNT: phase_next = PH_CHOOSE_SCT;
                    PH_CHOOSE_SCT: phase_next = v[0] ? PH_CHOOSE_IMV : PH_FORCE_SCT;
                    PH_FORCE_SCT:
                    begin
                        if (v[0])
                        begin
                            phase_next = PH_CHOOSE_IMV;
                        end
                        else
                        begin
                            phase_next = fl_oh_reg ? PH_OHBITS : PH_TAIL3;
                        end
                    end
                    PH_CHOOSE_IMV:
                    begin
                        if (!v[0])
                        begin
                            phase_next = PH_FORCE_IMV;
                        end
                        else
                        begin
                            phase_next = fl_oh_reg ? PH_OHBITS : PH_TAIL3;
                        end
                    end
                    PH_FORCE_IMV: phase_next = fl_oh_reg ? PH_OHBITS : PH_TAIL3;
                    PH_OHBITS: phase_next = PH_TAIL3;
                    PH_TAIL3: phase_next = PH_HBD;
                    PH_HBD:
                    begin
                        f_next.bit_depth = v[0] ? 4'd10 : 4'd8;
                        if (f_reg.profile == 3'd2 && v[0])
                        begin
                            phase_next = PH_TWELVE;
                        end
                        else if (f_reg.profile == 3'd1)
                        begin
                            f_next.monochrome = 1'b0;
                            phase_next = PH_CDP;
                        end
                        else
                        begin
                            phase_next = PH_MONO;
                        end
                    end
                    PH_TWELVE:
                    begin
                        if (v[0])
                        begin
                            f_next.bit_depth = 4'd12;
                        end
                        phase_next = PH_MONO;
                    end
                    PH_MONO:
                    begin
                        f_next.monochrome = v[0];
                        phase_next = PH_CDP;
                    end
                    PH_CDP:
                    begin
                        f_next.cdp = v[0];
                        if (v[0])
                        begin
                            phase_next = PH_CP;
                        end
                        else
                        begin
                            f_next.cp = CODE_UNSPEC;
                            f_next.tc = CODE_UNSPEC;
                            f_next.mc = CODE_UNSPEC;
                            phase_next = PH_RANGE;
                        end
                    end
                    PH_CP:
                    begin
                        f_next.cp = v;
                        phase_next = PH_TC;
                    end
                    PH_TC:
                    begin
                        f_next.tc = v;
                        phase_next = PH_MC;
                    end
                    PH_MC:
                    begin
                        f_next.mc = v;
                        if (!f_reg.monochrome && f_reg.cp == CP_BT709
                            && f_reg.tc == TC_SRGB && v == MC_IDENTITY)
                        begin
                            f_next.color_range = 1'b1;
                            f_next.chroma_format = 4'b0000;
                            phase_next = PH_SEPUV;
                        end
                        else
                        begin
                            phase_next = PH_RANGE;
                        end
                    end
                    PH_RANGE:
                    begin
                        f_next.color_range = v[0];
                        if (f_reg.monochrome)
                        begin
                            f_next.chroma_format = 4'b1100;
                            phase_next = PH_GRAIN;
                        end
                        else if (f_reg.profile == 3'd0)
                        begin
                            f_next.chroma_format = 4'b1100;
                            phase_next = PH_CSP;
                        end
                        else if (f_reg.profile == 3'd1)
                        begin
                            f_next.chroma_format = 4'b0000;
                            phase_next = PH_SEPUV;
                        end
                        else if (f_reg.bit_depth == 4'd12)
                        begin
                            phase_next = PH_SUBX;
                        end
                        else
                        begin
                            f_next.chroma_format = 4'b1000;
                            phase_next = PH_SEPUV;
                        end
                    end
                    PH_SUBX:
                    begin
                        if (v[0])
                        begin
                            phase_next = PH_SUBY;
                        end
                        else
                        begin
                            f_next.chroma_format = 4'b0000;
                            phase_next = PH_SEPUV;
                        end
                    end
                    PH_SUBY:
                    begin
                        if (v[0])
                        begin
                            f_next.chroma_format = 4'b1100;
                            phase_next = PH_CSP;
                        end
                        else
                        begin
                            f_next.chroma_format = 4'b1000;
                            phase_next = PH_SEPUV;
                        end
                    end
                    PH_CSP:
                    begin
                        f_next.chroma_format = {2'b11, v[1:0]};
                        phase_next = PH_SEPUV;
                    end
                    PH_SEPUV: phase_next = PH_GRAIN;
                    PH_GRAIN:
                    begin
                        done_next = 1'b1;
                    end
                    default: phase_next = PH_PROFILE;
                endcase
                if (phase_next == PH_DMPRES && !fl_dmi_reg)
                begin
                    phase_next = PH_IDDPRES;
                end
                if (phase_next == PH_IDDPRES && !fl_idd_reg)
                begin
                    phase_next = PH_FWB;
                end
                if (phase_next == PH_FWB && !fl_red_reg && phase_reg != PH_RLEVEL)
                begin
                    if (op_idx_reg < op_tot_reg)
                    begin
                        op_idx_next = op_idx_reg + 5'd1;
                        phase_next = PH_IDC;
                    end
                end
                if (phase_next == PH_MONO && f_reg.profile == 3'd1)
                begin
                    f_next.monochrome = 1'b0;
                    phase_next = PH_CDP;
                end
            end
        end

        if (ctrl.restart)
        begin
            phase_next  = PH_PROFILE;
            count_next  = '0;
            value_next  = '0;
            op_idx_next = '0;
            op_tot_next = '0;
            dly_next    = '0;
            sbw_next    = '0;
            sbh_next    = '0;
            uvlc_next   = '0;
            fl_red_next = 1'b0;
            fl_dmi_next = 1'b0;
            fl_idd_next = 1'b0;
            fl_oh_next  = 1'b0;
            done_next   = 1'b0;
            f_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_PROFILE;
            count_reg  <= '0;
            value_reg  <= '0;
            op_idx_reg <= '0;
            op_tot_reg <= '0;
            dly_reg    <= '0;
            sbw_reg    <= '0;
            sbh_reg    <= '0;
            uvlc_reg   <= '0;
            fl_red_reg <= 1'b0;
            fl_dmi_reg <= 1'b0;
            fl_idd_reg <= 1'b0;
            fl_oh_reg  <= 1'b0;
            done_reg   <= 1'b0;
            f_reg      <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            value_reg  <= value_next;
            op_idx_reg <= op_idx_next;
            op_tot_reg <= op_tot_next;
            dly_reg    <= dly_next;
            sbw_reg    <= sbw_next;
            sbh_reg    <= sbh_next;
            uvlc_reg   <= uvlc_next;
            fl_red_reg <= fl_red_next;
            fl_dmi_reg <= fl_dmi_next;
            fl_idd_reg <= fl_idd_next;
            fl_oh_reg  <= fl_oh_next;
            done_reg   <= done_next;
            f_reg      <= f_next;
        end
    end

endmodule

/* design/av1_sequence_header_parser_top.sv */
// Each accepted request carries one byte of a sequence header OBU body; the byte is
// shifted into the bit parser one bit per clock unless shifting pauses. A request is
// accepted in the idle state, its eight bits are shifted in the shift state and the output
// state closes the byte, so a new request is taken only once the last one is closed.
// Shifting of the film grain bit pauses while a finished record still waits in the output
// register, and a byte flagged last that ends a header early also waits for it to empty.
// A record appears once the film grain bit is parsed, or as a truncated status when a
// byte flagged last ends the header early; after any last byte the parser restarts.
// Top level of the AV1 sequence header parser; uses av1sh_pkg and av1sh_bit_parser.
module av1_sequence_header_parser_top
    import av1sh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // parse_status[0], profile[3:1], level[8:4], tier[9], bit_depth[13:10],
    // monochrome[14], chroma_format[18:15], color_description_present[19],
    // color_primaries[27:20], transfer_characteristics[35:28],
    // matrix_coefficients[43:36], color_range[44], zero fill[47:45]
    output logic [47:0] m_tdata
);

    ctrl_t      state_reg, state_next;
    logic [7:0] shift_reg, shift_next;
    logic [3:0] left_reg, left_next;
    logic       last_reg, last_next;
    logic       ovalid_reg, ovalid_next;
    logic [47:0] odata_reg, odata_next;
    bit_ctrl_t  bctrl;
    bit_stat_t  bstat;
    fields_t    flds;

    av1sh_bit_parser u_bits (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (bctrl),
        .stat   (bstat),
        .fields (flds)
    );

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;

    always_comb
    begin
        state_next  = state_reg;
        shift_next  = shift_reg;
        left_next   = left_reg;
        last_next   = last_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        s_tready    = 1'b0;
        bctrl       = '0;

        if (m_tready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    shift_next = s_tdata;
                    last_next  = s_tlast;
                    left_next  = 4'd8;
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                if (bstat.grain && ovalid_next)
                begin
                    bctrl = '0;
                end
                else
                begin
                    bctrl.bit_valid = 1'b1;
                    bctrl.bit_value = shift_reg[7];
                    shift_next = {shift_reg[6:0], 1'b0};
                    left_next  = left_reg - 4'd1;
                    if (left_reg == 4'd1)
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT:
            begin
                if (!ovalid_next || !last_reg || bstat.done)
                begin
                    if (last_reg)
                    begin
                        bctrl.restart = 1'b1;
                        if (!bstat.done)
                        begin
                            ovalid_next = 1'b1;
                            odata_next  = 48'd1;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (bstat.grain && bctrl.bit_valid)
        begin
            ovalid_next = 1'b1;
            odata_next  = {3'b000, flds.color_range, flds.mc, flds.tc, flds.cp,
                           flds.cdp, flds.chroma_format, flds.monochrome,
                           flds.bit_depth, flds.tier, flds.level, flds.profile,
                           1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            shift_reg  <= '0;
            left_reg   <= '0;
            last_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            odata_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            shift_reg  <= shift_next;
            left_reg   <= left_next;
            last_reg   <= last_next;
            ovalid_reg <= ovalid_next;
            odata_reg  <= odata_next;
        end
    end

endmodule
